// ----- hw/rtl/bfsd_pkg.sv -----
// bfsd_pkg: shared types and constants of the bloom filter string dedup core
// no dependencies; used by the controller, datapath and top level
package bfsd_pkg;

  // murmur3 constants
  localparam logic [31:0] MM_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2  = 32'h1b873593;
  localparam logic [31:0] MM_ADD = 32'he6546b64;
  localparam logic [31:0] MM_F1  = 32'h85ebca6b;
  localparam logic [31:0] MM_F2  = 32'hc2b2ae35;
  localparam logic [7:0]  SUFFIX_SEP  = 8'h5f;
  localparam logic [7:0]  SUFFIX_BASE = 8'd48;

  // register indexes and widths
  localparam int CFG_W = 5;
  localparam logic CFG_HASH_COUNT  = 1'b0;
  localparam logic CFG_INDEX_WIDTH = 1'b1;
  localparam logic [4:0] HASH_COUNT_RST  = 5'd7;
  localparam logic [4:0] INDEX_WIDTH_RST = 5'd16;
  localparam logic [4:0] INDEX_WIDTH_MIN = 5'd16;

  // store row geometry: 32 bits per row
  localparam int ROW_BITS = 5;
  // width for hash count compares, holds up to 127
  localparam int HC_CMP_W = 7;

  // operation codes
  localparam logic [1:0] OPC_TEST = 2'd0;
  localparam logic [1:0] OPC_ADD  = 2'd1;
  localparam logic [1:0] OPC_TADD = 2'd2;

  // datapath commands
  typedef enum logic [4:0] {
    OP_IDLE, OP_ACCEPT, OP_CLEAR, OP_KC1, OP_KC2, OP_MIXP, OP_TINIT, OP_MIXH,
    OP_TLOAD, OP_XORH, OP_FIN1, OP_FIN2, OP_FIN3, OP_TEST, OP_SRD, OP_SWR, OP_DONE
  } dp_op_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_PKC1, S_PKC2, S_PMIX, S_TINIT, S_FKC1, S_FKC2, S_FMIX,
    S_TLOAD, S_TKC1, S_TKC2, S_TXOR, S_FIN1, S_FIN2, S_FIN3, S_TEST, S_SRD,
    S_SWR, S_DONE
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic       in_fire;
    logic       blk_full;
    logic       key_end;
    logic [1:0] tail_n;
    logic       last_hash;
    logic       need_set;
    logic       out_busy;
    logic       clear_last;
  } dp_status_t;

endpackage

// ----- hw/rtl/bfsd_if.sv -----
// bfsd key and result channels: valid/ready with payload
// depends on nothing
interface bfsd_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;
  logic       last;
  logic [1:0] operation;
  modport source (output valid, key_byte, last, operation, input ready);
  modport sink (input valid, key_byte, last, operation, output ready);
endinterface

interface bfsd_result_if;
  logic valid;
  logic ready;
  logic present;
  modport source (output valid, present, input ready);
  modport sink (input valid, present, output ready);
endinterface

// ----- hw/rtl/bfsd_ctrl.sv -----
// bfsd_ctrl: sequencer for store clearing, byte mixing, per-hash tails, tests and sets
// depends on bfsd_pkg
module bfsd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  bfsd_pkg::dp_status_t status,
  output bfsd_pkg::dp_cmd_t    cmd
);

  bfsd_pkg::ctrl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= bfsd_pkg::S_CLEAR;
    else     state <= state_next;
  end

  // next state and command
  always_comb begin
    state_next = state;
    cmd.op = bfsd_pkg::OP_IDLE;
    case (state)
      bfsd_pkg::S_CLEAR: begin
        cmd.op = bfsd_pkg::OP_CLEAR;
        if (status.clear_last) state_next = bfsd_pkg::S_IDLE;
      end
      bfsd_pkg::S_IDLE: begin
        cmd.op = bfsd_pkg::OP_ACCEPT;
        if (status.in_fire) begin
          if (status.blk_full) state_next = bfsd_pkg::S_PKC1;
          else if (status.key_end) state_next = bfsd_pkg::S_TINIT;
        end
      end
      bfsd_pkg::S_PKC1: begin
        cmd.op = bfsd_pkg::OP_KC1; state_next = bfsd_pkg::S_PKC2;
      end
      bfsd_pkg::S_PKC2: begin
        cmd.op = bfsd_pkg::OP_KC2; state_next = bfsd_pkg::S_PMIX;
      end
      bfsd_pkg::S_PMIX: begin
        cmd.op = bfsd_pkg::OP_MIXP;
        state_next = status.key_end ? bfsd_pkg::S_TINIT : bfsd_pkg::S_IDLE;
      end
      bfsd_pkg::S_TINIT: begin
        cmd.op = bfsd_pkg::OP_TINIT;
        state_next = status.tail_n[1] ? bfsd_pkg::S_FKC1 : bfsd_pkg::S_TKC1;
      end
      bfsd_pkg::S_FKC1: begin
        cmd.op = bfsd_pkg::OP_KC1; state_next = bfsd_pkg::S_FKC2;
      end
      bfsd_pkg::S_FKC2: begin
        cmd.op = bfsd_pkg::OP_KC2; state_next = bfsd_pkg::S_FMIX;
      end
      bfsd_pkg::S_FMIX: begin
        cmd.op = bfsd_pkg::OP_MIXH;
        state_next = status.tail_n[0] ? bfsd_pkg::S_TLOAD : bfsd_pkg::S_FIN1;
      end
      bfsd_pkg::S_TLOAD: begin
        cmd.op = bfsd_pkg::OP_TLOAD; state_next = bfsd_pkg::S_TKC1;
      end
      bfsd_pkg::S_TKC1: begin
        cmd.op = bfsd_pkg::OP_KC1; state_next = bfsd_pkg::S_TKC2;
      end
      bfsd_pkg::S_TKC2: begin
        cmd.op = bfsd_pkg::OP_KC2; state_next = bfsd_pkg::S_TXOR;
      end
      bfsd_pkg::S_TXOR: begin
        cmd.op = bfsd_pkg::OP_XORH; state_next = bfsd_pkg::S_FIN1;
      end
      bfsd_pkg::S_FIN1: begin
        cmd.op = bfsd_pkg::OP_FIN1; state_next = bfsd_pkg::S_FIN2;
      end
      bfsd_pkg::S_FIN2: begin
        cmd.op = bfsd_pkg::OP_FIN2; state_next = bfsd_pkg::S_FIN3;
      end
      bfsd_pkg::S_FIN3: begin
        cmd.op = bfsd_pkg::OP_FIN3; state_next = bfsd_pkg::S_TEST;
      end
      bfsd_pkg::S_TEST: begin
        cmd.op = bfsd_pkg::OP_TEST;
        if (!status.last_hash) state_next = bfsd_pkg::S_TINIT;
        else if (status.need_set) state_next = bfsd_pkg::S_SRD;
        else state_next = bfsd_pkg::S_DONE;
      end
      bfsd_pkg::S_SRD: begin
        cmd.op = bfsd_pkg::OP_SRD; state_next = bfsd_pkg::S_SWR;
      end
      bfsd_pkg::S_SWR: begin
        cmd.op = bfsd_pkg::OP_SWR;
        state_next = status.last_hash ? bfsd_pkg::S_DONE : bfsd_pkg::S_SRD;
      end
      bfsd_pkg::S_DONE: begin
        if (!status.out_busy) begin
          cmd.op = bfsd_pkg::OP_DONE;
          state_next = bfsd_pkg::S_IDLE;
        end
      end
      default: state_next = bfsd_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/bfsd_dpath.sv -----
// bfsd_dpath: hash registers, murmur3 step unit, position list, bit store
// depends on bfsd_pkg and the bfsd channel interfaces
module bfsd_dpath #(
  parameter int MAX_INDEX_WIDTH = 20,
  parameter int MAX_HASHES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  bfsd_key_if.sink              key_in,
  bfsd_result_if.source         result_out,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [bfsd_pkg::CFG_W-1:0] cfg_data,
  input  bfsd_pkg::dp_cmd_t     cmd,
  output bfsd_pkg::dp_status_t  status
);

  localparam int IDXW = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam int RW = MAX_INDEX_WIDTH - bfsd_pkg::ROW_BITS;
  localparam int ROWS = 1 << RW;
  localparam int HW = bfsd_pkg::HC_CMP_W;

  logic [4:0]  hash_count, index_width;
  logic [31:0] prefix_hash, key_len, h, k;
  logic [23:0] pending;
  logic        key_end, all_set, out_valid, present;
  logic [1:0]  op_q;
  logic [IDXW-1:0] idx;
  logic [MAX_INDEX_WIDTH-1:0] pos_q [MAX_HASHES];
  logic [RW-1:0] clr_row, rd_row, wr_row;
  logic          clr_done, wr_en;
  logic [31:0]   rdata, wr_data;
  logic [31:0]   mem [ROWS];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_count  <= bfsd_pkg::HASH_COUNT_RST;
      index_width <= bfsd_pkg::INDEX_WIDTH_RST;
    end else if (cfg_we) begin
      if (cfg_index == bfsd_pkg::CFG_HASH_COUNT) hash_count <= cfg_data;
      else index_width <= cfg_data;
    end
  end

  // clamped hash count and fold width
  logic [HW-1:0] hc_ext, last_idx;
  logic [4:0]    fold_w;
  always_comb begin
    hc_ext = HW'(hash_count);
    if (hc_ext == '0) last_idx = '0;
    else if (hc_ext > HW'(MAX_HASHES)) last_idx = HW'(MAX_HASHES - 1);
    else last_idx = hc_ext - HW'(1);
    if (index_width < bfsd_pkg::INDEX_WIDTH_MIN) fold_w = bfsd_pkg::INDEX_WIDTH_MIN;
    else if (index_width > 5'(MAX_INDEX_WIDTH)) fold_w = 5'(MAX_INDEX_WIDTH);
    else fold_w = index_width;
  end

  // byte packing on accept
  logic [1:0]  n_in;
  logic [31:0] in_word;
  logic        in_fire;
  assign n_in    = key_len[1:0];
  assign in_fire = key_in.valid && key_in.ready;
  assign in_word = {8'h00, pending} | ({24'h0, key_in.key_byte} << {n_in, 3'b000});

  // suffix words for the current hash index
  logic [7:0]  digit;
  logic [31:0] suf_word;
  assign digit = bfsd_pkg::SUFFIX_BASE + 8'(idx);
  always_comb begin
    suf_word = {8'h00, pending}
             | ({24'h0, bfsd_pkg::SUFFIX_SEP} << {key_len[1:0], 3'b000});
    if (!key_len[1]) suf_word = suf_word | ({24'h0, digit} << {key_len[1:0] + 2'd1, 3'b000});
    else if (!key_len[0]) suf_word = suf_word | {digit, 24'h0};
  end

  // murmur3 step functions
  logic [31:0] k_rot, mix_src, mix_t, mix_r, mix_out, fin_x, fin_a, fin_b, fin_c;
  always_comb begin
    k_rot   = {k[16:0], k[31:17]};
    mix_src = (cmd.op == bfsd_pkg::OP_MIXP) ? prefix_hash : h;
    mix_t   = mix_src ^ k;
    mix_r   = {mix_t[18:0], mix_t[31:19]};
    mix_out = (mix_r << 2) + mix_r + bfsd_pkg::MM_ADD;
    fin_x   = h ^ (key_len + 32'd2);
    fin_a   = fin_x ^ (fin_x >> 16);
    fin_b   = h ^ (h >> 13);
    fin_c   = h ^ (h >> 16);
  end

  // fold of the finished hash to a bit position
  logic [31:0] fold_mask, fold_v;
  logic [MAX_INDEX_WIDTH-1:0] pos_new, pos_cur;
  assign fold_mask = (32'h1 << fold_w) - 32'h1;
  assign fold_v    = (fin_c >> fold_w) ^ (fin_c & fold_mask);
  assign pos_new   = fold_v[MAX_INDEX_WIDTH-1:0];
  assign pos_cur   = pos_q[idx];

  // current bit of the registered row
  logic cur_bit;
  assign cur_bit = rdata[pos_cur[bfsd_pkg::ROW_BITS-1:0]];

  // working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_hash <= '0;
      pending     <= '0;
      key_len     <= '0;
      key_end     <= 1'b0;
      idx         <= '0;
      all_set     <= 1'b1;
      op_q        <= bfsd_pkg::OPC_TEST;
    end else begin
      case (cmd.op)
        bfsd_pkg::OP_ACCEPT: begin
          if (in_fire) begin
            key_len <= key_len + 32'd1;
            key_end <= key_in.last;
            if (n_in == 2'd3) begin
              k <= in_word;
              pending <= '0;
            end else begin
              pending <= in_word[23:0];
            end
            if (key_in.last) begin
              op_q    <= key_in.operation;
              idx     <= '0;
              all_set <= 1'b1;
            end
          end
        end
        bfsd_pkg::OP_KC1:   k <= k * bfsd_pkg::MM_C1;
        bfsd_pkg::OP_KC2:   k <= k_rot * bfsd_pkg::MM_C2;
        bfsd_pkg::OP_MIXP:  prefix_hash <= mix_out;
        bfsd_pkg::OP_TINIT: begin
          h <= prefix_hash;
          k <= suf_word;
        end
        bfsd_pkg::OP_MIXH:  h <= mix_out;
        bfsd_pkg::OP_TLOAD: k <= {24'h0, digit};
        bfsd_pkg::OP_XORH:  h <= h ^ k;
        bfsd_pkg::OP_FIN1:  h <= fin_a * bfsd_pkg::MM_F1;
        bfsd_pkg::OP_FIN2:  h <= fin_b * bfsd_pkg::MM_F2;
        bfsd_pkg::OP_FIN3:  pos_q[idx] <= pos_new;
        bfsd_pkg::OP_TEST: begin
          all_set <= all_set & cur_bit;
          idx <= status.last_hash ? '0 : idx + IDXW'(1);
        end
        bfsd_pkg::OP_SWR:   idx <= status.last_hash ? '0 : idx + IDXW'(1);
        bfsd_pkg::OP_DONE: begin
          prefix_hash <= '0;
          pending     <= '0;
          key_len     <= '0;
          key_end     <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row  <= '0;
      clr_done <= 1'b0;
    end else if (cmd.op == bfsd_pkg::OP_CLEAR) begin
      clr_row <= clr_row + RW'(1);
      if (clr_row == '1) clr_done <= 1'b1;
    end
  end

  // bit store ports
  always_comb begin
    rd_row = (cmd.op == bfsd_pkg::OP_FIN3) ? pos_new[MAX_INDEX_WIDTH-1:bfsd_pkg::ROW_BITS]
                                           : pos_cur[MAX_INDEX_WIDTH-1:bfsd_pkg::ROW_BITS];
    wr_en  = (cmd.op == bfsd_pkg::OP_CLEAR) || (cmd.op == bfsd_pkg::OP_SWR);
    wr_row = (cmd.op == bfsd_pkg::OP_CLEAR) ? clr_row
                                            : pos_cur[MAX_INDEX_WIDTH-1:bfsd_pkg::ROW_BITS];
    wr_data = (cmd.op == bfsd_pkg::OP_CLEAR) ? 32'h0
            : (rdata | (32'h1 << pos_cur[bfsd_pkg::ROW_BITS-1:0]));
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_row] <= wr_data;
    rdata <= mem[rd_row];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == bfsd_pkg::OP_DONE) begin
      out_valid <= 1'b1;
      present   <= (op_q == bfsd_pkg::OPC_ADD) ? 1'b0 : all_set;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result_out.valid   = out_valid;
  assign result_out.present = present;
  assign key_in.ready       = (cmd.op == bfsd_pkg::OP_ACCEPT);

  // status to the controller
  always_comb begin
    status.in_fire    = in_fire;
    status.blk_full   = (n_in == 2'd3);
    status.key_end    = (cmd.op == bfsd_pkg::OP_ACCEPT) ? key_in.last : key_end;
    status.tail_n     = key_len[1:0];
    status.last_hash  = (HW'(idx) == last_idx);
    status.need_set   = (op_q == bfsd_pkg::OPC_ADD)
                     || ((op_q == bfsd_pkg::OPC_TADD) && !(all_set && cur_bit));
    status.out_busy   = out_valid && !result_out.ready;
    status.clear_last = (clr_row == '1);
  end

  // no byte taken before the store is cleared
  a_ready_after_clear: assert property (@(posedge clk) disable iff (rst)
    key_in.ready |-> clr_done)
    else $error("byte accepted during clearing sweep");

  // hash index stays within the clamped count while testing
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == bfsd_pkg::OP_TEST) |-> (HW'(idx) <= last_idx))
    else $error("hash index beyond count");

  // key state restarts after each result
  a_key_restart: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == bfsd_pkg::OP_DONE) |=> (key_len == '0 && result_out.valid))
    else $error("key state not restarted");

endmodule

// ----- hw/rtl/bloom_filter_string_dedup_core.sv -----
// bloom_filter_string_dedup_core: bloom filter over byte-string keys, murmur3 hashing
// depends on bfsd_pkg, bfsd_if, bfsd_ctrl, bfsd_dpath
// a byte that completes a block is mixed into the prefix hash; at a key end each hash
// is finished and tested with one store read, bits are set by a read and a write per
// hash when needed, then the result word goes out; reset is synchronous, and a sweep
// then clears the bit store one 32-bit row a cycle; no key byte is taken until it ends
module bloom_filter_string_dedup_core #(
  parameter int MAX_INDEX_WIDTH = 20,
  parameter int MAX_HASHES = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  bfsd_key_if.sink                   key_in,
  bfsd_result_if.source              result_out,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [bfsd_pkg::CFG_W-1:0] cfg_data
);

  bfsd_pkg::dp_cmd_t    cmd;
  bfsd_pkg::dp_status_t status;

  // sequencer
  bfsd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // hashing and bit store
  bfsd_dpath #(
    .MAX_INDEX_WIDTH (MAX_INDEX_WIDTH),
    .MAX_HASHES      (MAX_HASHES)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .key_in     (key_in),
    .result_out (result_out),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status)
  );

endmodule
